/* src/pixel_channel_format_converter_top_assert.svh */
`ifndef PIXEL_CHANNEL_FORMAT_CONVERTER_TOP_ASSERT_SVH
`define PIXEL_CHANNEL_FORMAT_CONVERTER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during rst
`define PCFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define PCFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pcfc_pkg.sv */
package pcfc_pkg;

  localparam logic [31:0] EXP_MASK32 = 32'h7f800000;
  localparam logic [31:0] REBIAS     = 32'h38000000;
  localparam logic [31:0] ONE_F32    = 32'h3f800000;
  localparam logic [31:0] ALL_ONES   = 32'hffffffff;
  localparam logic [23:0] HIDDEN_ONE = 24'h800000;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_UNORM  = 2'd0,
    KIND_FLOAT  = 2'd1,
    KIND_UINT   = 2'd2,
    KIND_SIGNED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PATH_DIRECT    = 2'd0,
    PATH_UNORM_ENC = 2'd1,
    PATH_I2F       = 2'd2,
    PATH_REPEAT    = 2'd3
  } path_t;

  typedef struct packed {
    path_t       path;
    logic [31:0] direct;
    logic        status;
    logic [31:0] mask;
    logic [23:0] mant;
    logic [23:0] mm;
    logic [7:0]  rsh;
    logic [31:0] v;
    logic [5:0]  lz;
    logic [5:0]  adj;
    logic [5:0]  w;
  } s1_t;

  typedef struct packed {
    path_t       path;
    logic [31:0] direct;
    logic        status;
    logic [31:0] mask;
    logic [47:0] prod;
    logic [7:0]  rsh;
    logic [31:0] word;
    logic [7:0]  exp;
    logic [5:0]  w;
  } s2_t;

  typedef struct packed {
    path_t       path;
    logic [31:0] direct;
    logic        status;
    logic [31:0] mask;
    logic [24:0] rnd;
    logic [4:0]  k;
    logic [7:0]  rsh;
    logic [24:0] rep;
    logic [7:0]  exp;
  } s3_t;

  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(input logic [47:0] x);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (x[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

endpackage

/* src/pixel_channel_format_converter_top.sv */
// an accepted request passes the classify stage, stages 2 and 3 and the output register
// throughput: one request per cycle while the output is not stalled, in every mode and direction
// the depth is set by the 24x24 product and its rounding on the unorm path
// a stalled output holds the pipeline, nothing is dropped or repeated
// rst (synchronous, active high) empties every stage; no other state
module pixel_channel_format_converter_top import pcfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // value_bits[31:0], channel_width[37:32], zero pad
  input  logic [2:0]  s_axis_tuser,   // opcode[0], channel_kind[2:1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result_bits[31:0]
  output logic [0:0]  m_axis_tuser    // status[0]
);

`include "pixel_channel_format_converter_top_assert.svh"

  logic        s1_valid;
  logic        s1_ready;
  s1_t         s1;
  logic        s3_valid;
  logic        s3_ready;
  s3_t         s3;
  logic [48:0] ftmp;
  logic [24:0] rsum;
  logic [31:0] res_next;

  pcfc_classify u_classify (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1)
  );

  pcfc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1       (s1),
    .s3_valid (s3_valid),
    .s3_ready (s3_ready),
    .s3       (s3)
  );

  always_comb begin
    ftmp = ({24'd0, s3.rnd} << s3.k) >> s3.rsh;
    rsum = {1'b0, s3.rep[24:1]} + {24'd0, s3.rep[0]};
    unique case (s3.path)
      PATH_UNORM_ENC: begin
        if (ftmp > {17'd0, s3.mask}) res_next = s3.mask;
        else res_next = ftmp[31:0];
      end
      PATH_REPEAT: begin
        if (rsum[24]) res_next = {1'b0, s3.exp + 8'd1, 23'd0};
        else res_next = {1'b0, s3.exp, rsum[22:0]};
      end
      default: res_next = s3.direct;
    endcase
  end

  assign s3_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s3_ready) begin
      m_axis_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s3_valid) begin
      m_axis_tdata    <= s3.status ? 32'd0 : res_next;
      m_axis_tuser[0] <= s3.status;
    end
  end

  `PCFC_ASSERT_IMP(a_unsup_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'd0, "unsupported result not zero")
  `PCFC_ASSERT_NXT(a_s3_hold, s3_valid && !s3_ready, s3_valid && $stable(s3), "stage 3 lost data in stall")
  `PCFC_ASSERT_IMP(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")

endmodule

/* src/pcfc_classify.sv */
module pcfc_classify import pcfc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [39:0] in_data,   // value_bits, channel_width, zero pad
  input  logic [2:0]  in_user,   // opcode, channel_kind
  output logic        s1_valid,
  input  logic        s1_ready,
  output s1_t         s1
);

  logic [31:0] u;
  logic [5:0]  w;
  logic        op;
  kind_t       kind;
  logic [31:0] mask;
  logic [31:0] vm;
  logic [5:0]  lz;
  logic [30:0] mag;
  logic        is_zero;
  logic        is_inf;
  logic        is_nan;
  logic [31:0] erb;
  logic [7:0]  ef;
  logic [23:0] fm;
  logic [31:0] enc_f;
  logic [31:0] dec_f;
  logic        f_ok;
  logic [31:0] ut;
  logic [7:0]  ue;
  logic [9:0]  rsh_w;
  logic [5:0]  me;
  s1_t         s1_next;
  logic        adv;

  assign u    = in_data[31:0];
  assign w    = in_data[37:32];
  assign op   = in_user[0];
  assign kind = kind_t'(in_user[2:1]);
  assign mask = ~(ALL_ONES << w);
  assign vm   = u & mask;
  assign lz   = lzc32(vm);
  assign mag  = u[30:0];
  assign is_zero = (mag == 31'd0);
  assign is_inf  = (mag == EXP_MASK32[30:0]);
  assign is_nan  = (mag > EXP_MASK32[30:0]);
  assign erb  = (u & EXP_MASK32) - REBIAS;
  assign ef   = u[30:23];
  assign fm   = {(ef != 8'd0), u[22:0]};
  assign f_ok = (w == 6'd32) || (w == 6'd16) || (w == 6'd11) || (w == 6'd10);
  assign me   = (w > 6'd24) ? (w - 6'd23) : 6'd0;

  always_comb begin
    enc_f = 32'd0;
    if (w == 6'd32) begin
      enc_f = u;
    end else if (w == 6'd16) begin
      if (is_zero) enc_f = 32'd0;
      else if (is_nan) enc_f = ALL_ONES;
      else if (is_inf) enc_f = u[31] ? 32'hfc00 : 32'h7c00;
      else enc_f = ((u >> 16) & 32'h8000) | ((erb >> 13) & 32'h7c00) | ((u >> 13) & 32'h03ff);
    end else if (w == 6'd11) begin
      if (is_zero) enc_f = 32'd0;
      else if (is_nan) enc_f = ALL_ONES;
      else if (is_inf) enc_f = 32'h07c0;
      else enc_f = ((erb >> 17) & 32'h07c0) | ((u >> 17) & 32'h003f);
    end else if (w == 6'd10) begin
      if (is_zero) enc_f = 32'd0;
      else if (is_nan) enc_f = ALL_ONES;
      else if (is_inf) enc_f = 32'h03e0;
      else enc_f = ((erb >> 18) & 32'h03e0) | ((u >> 18) & 32'h001f);
    end
  end

  always_comb begin
    dec_f = 32'd0;
    if (w == 6'd32) begin
      dec_f = vm;
    end else if (w == 6'd16) begin
      dec_f = ((vm & 32'h8000) << 16) | (((vm & 32'h7c00) + 32'h1c000) << 13)
            | ((vm & 32'h03ff) << 13);
    end else if (w == 6'd11) begin
      dec_f = ((((vm & 32'h07c0) << 17) + REBIAS) & EXP_MASK32) | ((vm & 32'h003f) << 17);
    end else if (w == 6'd10) begin
      dec_f = ((((vm & 32'h03e0) << 18) + REBIAS) & EXP_MASK32) | ((vm & 32'h001f) << 18);
    end
  end

  // float to uint, truncating and saturating
  always_comb begin
    ut = 32'd0;
    ue = 8'd0;
    if (u[31] || is_nan || is_zero) begin
      ut = 32'd0;
    end else if (ef >= 8'd159) begin
      ut = mask;
    end else begin
      if (ef >= 8'd150) ue = ef - 8'd150;
      else ue = 8'd150 - ef;
      if (ef >= 8'd150) ut = {8'd0, fm} << ue;
      else ut = {8'd0, fm} >> ue;
      if (ut > mask) ut = mask;
    end
  end

  always_comb begin
    s1_next        = '0;
    s1_next.path   = PATH_DIRECT;
    s1_next.mask   = mask;
    s1_next.v      = vm;
    s1_next.w      = w;
    rsh_w          = 10'd0;
    if (w == 6'd0 || w > 6'd32 || kind == KIND_SIGNED) begin
      s1_next.status = 1'b1;
    end else if (op == OP_ENCODE) begin
      unique case (kind)
        KIND_UNORM: begin
          if (!(is_nan || u[31] || is_zero)) begin
            s1_next.path = PATH_UNORM_ENC;
            s1_next.mm   = (w > 6'd24) ? HIDDEN_ONE : mask[23:0];
            if (mag > ONE_F32[30:0]) begin
              s1_next.mant = HIDDEN_ONE;
              rsh_w = 10'd150 - 10'd127 - {4'd0, me};
            end else begin
              s1_next.mant = fm;
              rsh_w = 10'd150 - ((ef == 8'd0) ? 10'd1 : {2'd0, ef}) - {4'd0, me};
            end
            s1_next.rsh = rsh_w[7:0];
          end
        end
        KIND_FLOAT: begin
          if (f_ok) s1_next.direct = enc_f & mask;
          else s1_next.status = 1'b1;
        end
        KIND_UINT: s1_next.direct = ut;
        default: s1_next.status = 1'b1;
      endcase
    end else begin
      unique case (kind)
        KIND_UNORM: begin
          if (vm == 32'd0) begin
            s1_next.direct = 32'd0;
          end else if (w <= 6'd24) begin
            if (vm == mask) begin
              s1_next.direct = ONE_F32;
            end else begin
              s1_next.path = PATH_REPEAT;
              s1_next.lz   = lz - (6'd32 - w);
            end
          end else begin
            s1_next.path = PATH_I2F;
            s1_next.lz   = lz;
            s1_next.adj  = w;
          end
        end
        KIND_FLOAT: begin
          if (f_ok) s1_next.direct = dec_f;
          else s1_next.status = 1'b1;
        end
        KIND_UINT: begin
          if (vm != 32'd0) begin
            s1_next.path = PATH_I2F;
            s1_next.lz   = lz;
          end
        end
        default: s1_next.status = 1'b1;
      endcase
    end
  end

  assign adv      = !s1_valid || s1_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      s1 <= s1_next;
    end
  end

endmodule

/* src/pcfc_core.sv */
module pcfc_core import pcfc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s1_valid,
  output logic s1_ready,
  input  s1_t  s1,
  output logic s3_valid,
  input  logic s3_ready,
  output s3_t  s3
);

  logic        s2_valid;
  s2_t         s2;
  s2_t         s2_next;
  s3_t         s3_next;
  logic        adv2;
  logic        adv3;
  logic [31:0] rot;
  logic [8:0]  e_i2f;
  logic [5:0]  lzp;
  logic [5:0]  n;
  logic [4:0]  k;
  logic [47:0] q;
  logic        g;
  logic        st;
  logic        inc;
  logic [23:0] im;
  logic [24:0] isum;
  logic [63:0] r;

  // stage 2: product, normalise, rotate
  always_comb begin
    s2_next        = '0;
    s2_next.path   = s1.path;
    s2_next.direct = s1.direct;
    s2_next.status = s1.status;
    s2_next.mask   = s1.mask;
    s2_next.rsh    = s1.rsh;
    s2_next.w      = s1.w;
    s2_next.prod   = {24'd0, s1.mant} * {24'd0, s1.mm};
    rot   = ((s1.v << s1.lz) | (s1.v >> (s1.w - s1.lz))) & s1.mask;
    e_i2f = 9'd158 - {3'd0, s1.lz} - {3'd0, s1.adj};
    if (s1.path == PATH_REPEAT) begin
      s2_next.word = rot << (6'd32 - s1.w);
      s2_next.exp  = 8'd126 - {2'd0, s1.lz};
    end else begin
      s2_next.word = s1.v << s1.lz;
      s2_next.exp  = e_i2f[7:0];
    end
  end

  // stage 3: rounding of product and int conversion, repeat expansion
  always_comb begin
    s3_next        = '0;
    s3_next.path   = s2.path;
    s3_next.direct = s2.direct;
    s3_next.status = s2.status;
    s3_next.mask   = s2.mask;
    s3_next.rsh    = s2.rsh;
    s3_next.exp    = s2.exp;

    lzp = lzc48(s2.prod);
    n   = 6'd47 - lzp;
    k   = (s2.prod != 48'd0 && n > 6'd23) ? 5'(n - 6'd23) : 5'd0;
    q   = s2.prod >> k;
    if (k != 5'd0) begin
      g  = s2.prod[k - 5'd1];
      st = (s2.prod & ((48'd1 << (k - 5'd1)) - 48'd1)) != 48'd0;
    end else begin
      g  = 1'b0;
      st = 1'b0;
    end
    s3_next.rnd = q[24:0] + {24'd0, g && (st || q[0])};
    s3_next.k   = k;

    im   = s2.word[31:8];
    inc  = s2.word[7] && ((|s2.word[6:0]) || im[0]);
    isum = {1'b0, im} + {24'd0, inc};
    if (s2.path == PATH_I2F) begin
      s3_next.path = PATH_DIRECT;
      if (isum[24]) s3_next.direct = {1'b0, s2.exp + 8'd1, 23'd0};
      else s3_next.direct = {1'b0, s2.exp, isum[22:0]};
    end

    r = {s2.word, 32'd0};
    for (int i = 0; i < 6; i++) begin
      r = r | (r >> ({5'd0, s2.w} << i));
    end
    s3_next.rep = r[63:39];
  end

  assign adv3     = !s3_valid || s3_ready;
  assign adv2     = !s2_valid || adv3;
  assign s1_ready = adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) s2 <= s2_next;
    if (adv3 && s2_valid) s3 <= s3_next;
  end

endmodule
